// ===== design/tsl_pkg.sv =====
`timescale 1ns / 1ps

package tsl_pkg;

    // Window and field widths
    localparam int WIN_LEN  = 19;
    localparam int HIST_LEN = WIN_LEN - 1;
    localparam int IDX_W    = $clog2(WIN_LEN);
    localparam int POS_W    = 16;
    localparam int SPAN_W   = 5;
    localparam int LEN_W    = 6;
    localparam int CAP_W    = 7;

    localparam int BUFFER_BYTES        = 65536;
    localparam int MAX_FRACTION_DIGITS = 10;

    localparam logic [POS_W-1:0]  POS_MAX    = '1;
    localparam logic [POS_W:0]    POS_LIMIT  = (POS_W+1)'(BUFFER_BYTES);
    localparam logic [POS_W-1:0]  POS_FIRST  = POS_W'(HIST_LEN);
    localparam logic [SPAN_W-1:0] SPAN_BASE  = SPAN_W'(WIN_LEN);
    localparam logic [SPAN_W-1:0] SPAN_SEP   = SPAN_W'(WIN_LEN + 1);
    localparam logic [SPAN_W-1:0] SPAN_FULL  = SPAN_W'(WIN_LEN + 1 + MAX_FRACTION_DIGITS);
    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(32);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DATE_CAPACITY = 1'b0;

    // Characters of the pattern
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Places of the fixed characters in the window
    localparam logic [IDX_W-1:0] POS_DASH_A  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_DASH_B  = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_SPACE   = IDX_W'(10);
    localparam logic [IDX_W-1:0] POS_COLON_A = IDX_W'(13);
    localparam logic [IDX_W-1:0] POS_COLON_B = IDX_W'(16);

    typedef enum logic [3:0] {
        MODE_SEARCH   = 4'b0001,
        MODE_MATCHED  = 4'b0010,
        MODE_FRACTION = 4'b0100,
        MODE_DONE     = 4'b1000
    } scan_mode_t;

    typedef struct packed {
        logic              emit;
        logic              found;
        logic [POS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } tsl_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic pattern_ok(input logic [IDX_W-1:0] k, input logic [7:0] c);
        logic ok;
        case (k)
            POS_DASH_A, POS_DASH_B:   ok = (c == CH_DASH);
            POS_SPACE:                ok = (c == CH_SPACE);
            POS_COLON_A, POS_COLON_B: ok = (c == CH_COLON);
            default:                  ok = is_digit(c);
        endcase
        return ok;
    endfunction

endpackage

// ===== design/timestamp_locator_in_byte_stream_unit.sv =====
`timescale 1ns / 1ps
// A byte word that ends a scan gives its result word through the input register, then the
// result register.
// One byte word per cycle unless byte_stall is high (a result waits on a stalled output).
// Reset (rst_n, asynchronous, active low) clears the scan state, the valid flags and sets
// date_capacity to 32; the byte history is not cleared.

module timestamp_locator_in_byte_stream_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tsl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tsl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            last_of_buffer,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            found,
    output logic [tsl_pkg::POS_W-1:0]       match_offset,
    output logic [tsl_pkg::LEN_W-1:0]       match_length
);
    import tsl_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [POS_W-1:0]  offset_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              win_match;
    logic              out_free;
    logic              s1_go;
    logic              take_in;
    logic              cfg_wr;
    tsl_result_t       res;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_DATE_CAPACITY);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_DATE_CAPACITY)
                  ? {{(APB_DATA_W-CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Handshake: advance the input stage when its word has somewhere to go
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_go      = s1_valid_reg && (!res.emit || out_free);
    assign byte_stall = s1_valid_reg && !s1_go;
    assign take_in    = byte_valid && !byte_stall;

    assign s1_valid_next  = take_in ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = (s1_go && res.emit) ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the input word
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_of_buffer;
        end
    end

    tsl_window u_window (
        .clk       (clk),
        .advance   (s1_go),
        .cur_byte  (s1_byte_reg),
        .win_match (win_match)
    );

    tsl_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (s1_go),
        .cur_byte      (s1_byte_reg),
        .cur_last      (s1_last_reg),
        .win_match     (win_match),
        .date_capacity (cap_reg),
        .res           (res)
    );

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (s1_go && res.emit)
        begin
            found_reg  <= res.found;
            offset_reg <= res.offset;
            length_reg <= res.length;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;
    assign match_length = length_reg;

`ifndef ASSERT_OFF
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> s1_valid_reg)
        else $error("input stalled with no word held");

    a_stall_needs_blocked_out: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (out_valid_reg && result_stall && res.emit))
        else $error("input stalled while the result register is free");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (match_offset == '0 && match_length == '0))
        else $error("not-found result carries offset or length");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> (match_length <= LEN_W'(SPAN_FULL)))
        else $error("match length beyond the longest span");
`endif

endmodule

// ===== design/tsl_window.sv =====
`timescale 1ns / 1ps

module tsl_window (
    input  logic       clk,
    input  logic       advance,
    input  logic [7:0] cur_byte,
    output logic       win_match
);
    import tsl_pkg::*;

    // Oldest byte at index 0, newest at the top
    logic [7:0] hist_reg  [HIST_LEN];
    logic [7:0] hist_next [HIST_LEN];

    // Shift the history by one byte
    always_comb
    begin
        for (int i = 0; i < HIST_LEN - 1; i++)
        begin
            hist_next[i] = hist_reg[i+1];
        end
        hist_next[HIST_LEN-1] = cur_byte;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_reg <= hist_next;
        end
    end

    // Compare every place of the window at once
    always_comb
    begin
        win_match = pattern_ok(IDX_W'(HIST_LEN), cur_byte);
        for (int i = 0; i < HIST_LEN; i++)
        begin
            win_match = win_match & pattern_ok(IDX_W'(i), hist_reg[i]);
        end
    end

endmodule

// ===== design/tsl_scan.sv =====
`timescale 1ns / 1ps

module tsl_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [7:0]                 cur_byte,
    input  logic                       cur_last,
    input  logic                       win_match,
    input  logic [tsl_pkg::CAP_W-1:0]  date_capacity,
    output tsl_pkg::tsl_result_t       res
);
    import tsl_pkg::*;

    scan_mode_t        mode_reg,   mode_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [POS_W-1:0]  offset_reg, offset_next;
    logic [SPAN_W-1:0] span_reg,   span_next;
    logic [SPAN_W-1:0] span_inc;
    logic              live;
    logic              is_sep;
    logic              hit;

    assign live     = (pos_reg != POS_MAX) && ({1'b0, pos_reg} < POS_LIMIT);
    assign is_sep   = (cur_byte == CH_DOT) || (cur_byte == CH_COMMA);
    assign span_inc = span_reg + SPAN_W'(1);

    // Step the scan for the current byte
    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        span_next   = span_reg;
        res.emit    = 1'b0;
        hit         = 1'b0;
        case (mode_reg)
            MODE_SEARCH:
            begin
                if (live && (pos_reg >= POS_FIRST) && win_match)
                begin
                    offset_next = pos_reg - POS_FIRST;
                    span_next   = SPAN_BASE;
                    mode_next   = MODE_MATCHED;
                    res.emit    = cur_last;
                    hit         = cur_last;
                end
                else
                begin
                    res.emit = cur_last;
                end
            end
            MODE_MATCHED:
            begin
                if (live && is_sep)
                begin
                    span_next = SPAN_SEP;
                    mode_next = MODE_FRACTION;
                    res.emit  = cur_last;
                    hit       = cur_last;
                end
                else
                begin
                    res.emit  = 1'b1;
                    hit       = 1'b1;
                    mode_next = MODE_DONE;
                end
            end
            MODE_FRACTION:
            begin
                if (live && is_digit(cur_byte))
                begin
                    span_next = span_inc;
                    if ((span_inc >= SPAN_FULL) || cur_last)
                    begin
                        res.emit  = 1'b1;
                        hit       = 1'b1;
                        mode_next = MODE_DONE;
                    end
                end
                else
                begin
                    res.emit  = 1'b1;
                    hit       = 1'b1;
                    mode_next = MODE_DONE;
                end
            end
            MODE_DONE:
            begin
                mode_next = MODE_DONE;
            end
            default:
            begin
                mode_next = MODE_SEARCH;
            end
        endcase

        // Form the result, clamping the span below the capacity
        res.found  = hit;
        res.offset = hit ? offset_next : '0;
        if (!hit)
        begin
            res.length = '0;
        end
        else if ({{(CAP_W-SPAN_W){1'b0}}, span_next} >= date_capacity)
        begin
            res.length = (date_capacity == '0) ? '0 : LEN_W'(date_capacity - CAP_W'(1));
        end
        else
        begin
            res.length = LEN_W'(span_next);
        end

        // Drop all buffer state after the final byte
        if (cur_last)
        begin
            mode_next   = MODE_SEARCH;
            offset_next = '0;
            span_next   = SPAN_BASE;
            pos_next    = '0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEARCH;
            pos_reg    <= '0;
            offset_reg <= '0;
            span_reg   <= SPAN_BASE;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            span_reg   <= span_next;
        end
    end

endmodule
